// File: hdl/qbsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbsa_pkg
// Shared types and fixed widths for the QRS bandpass / square / average block.
// ----------------------------------------------------------------------------
package qbsa_pkg;

	localparam int COEF_W    = 32;   // Q5.27 coefficients
	localparam int Y_W       = 32;   // Q20.12 filter output
	localparam int PROD_W    = 64;
	localparam int ACC_W     = 58;   // Q.27 accumulator, ten terms
	localparam int FB_SHIFT  = 12;   // Q.39 feedback product back to Q.27
	localparam int OUT_SHIFT = 15;   // Q.27 to Q.12
	localparam int INT_SHIFT = 12;   // Q.12 to integer part
	localparam int IP_W      = Y_W - INT_SHIFT;
	localparam int RND_W     = ACC_W - OUT_SHIFT;
	localparam int SQ_W      = 40;
	localparam int SUM_W     = 46;
	localparam int CNT_W     = 6;    // holds any window length up to 63
	localparam int DIV_CNT_W = 6;    // holds SUM_W
	localparam int HIST      = 6;
	localparam int NUM_REGS  = 8;
	localparam int REG_IDX_W = 3;

	localparam logic [ACC_W-1:0] ROUND_ADD = ACC_W'(1) << (OUT_SHIFT - 1);

	localparam logic [REG_IDX_W-1:0] REG_B_OUTER = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_B_INNER = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_A1      = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_A2      = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_A3      = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_A4      = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_A5      = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_A6      = 3'd7;

	localparam logic signed [COEF_W-1:0] COEF_RESET [NUM_REGS] = '{
		32'sd126341,
		-32'sd379023,
		-32'sd730934902,
		32'sd1676546148,
		-32'sd2073005291,
		32'sd1457375014,
		-32'sd552403916,
		32'sd88217917
	};

	// one multiply per step through the shared multiplier; MS_DRAIN multiplies nothing
	typedef enum logic [3:0] {
		MS_X0    = 4'd0,
		MS_X2    = 4'd1,
		MS_X4    = 4'd2,
		MS_X6    = 4'd3,
		MS_Y1    = 4'd4,
		MS_Y2    = 4'd5,
		MS_Y3    = 4'd6,
		MS_Y4    = 4'd7,
		MS_Y5    = 4'd8,
		MS_Y6    = 4'd9,
		MS_DRAIN = 4'd10
	} mac_step_t;

	typedef struct packed {
		logic valid;
		logic sub;
		logic fb;
	} mac_term_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// File: hdl/qbsa_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbsa_div
// Restoring divider, one quotient bit per cycle, window sum by item count.
// ----------------------------------------------------------------------------
module qbsa_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [qbsa_pkg::SUM_W-1:0]  dividend,
	input  logic [qbsa_pkg::CNT_W-1:0]  divisor,
	output qbsa_pkg::div_stat_t         stat,
	output logic [qbsa_pkg::SUM_W-1:0]  quotient
);

	logic                            busy_q;
	logic                            done_q;
	logic [qbsa_pkg::DIV_CNT_W-1:0]  bits_q;
	logic [qbsa_pkg::CNT_W-1:0]      rem_q;
	logic [qbsa_pkg::CNT_W-1:0]      dsor_q;
	logic [qbsa_pkg::SUM_W-1:0]      quo_q;

	logic [qbsa_pkg::CNT_W:0] trial;
	logic [qbsa_pkg::CNT_W:0] diff;
	logic                     ge;

	// dividend bits leave quo_q at the top while quotient bits enter at the bottom
	assign trial = {rem_q, quo_q[qbsa_pkg::SUM_W-1]};
	assign ge    = trial >= {1'b0, dsor_q};
	assign diff  = trial - {1'b0, dsor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bits_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				bits_q <= qbsa_pkg::DIV_CNT_W'(qbsa_pkg::SUM_W);
			end else if (busy_q) begin
				bits_q <= bits_q - 1'b1;
				if (bits_q == qbsa_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q  <= dividend;
			rem_q  <= '0;
			dsor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[qbsa_pkg::CNT_W-1:0] : trial[qbsa_pkg::CNT_W-1:0];
			quo_q <= {quo_q[qbsa_pkg::SUM_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q && !done_q)
		else $error("divider restarted while working");

	a_nonzero_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !$rose(busy_q) |-> dsor_q != '0)
		else $error("divide by zero count");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $fell(busy_q))
		else $error("done without a finished division");

endmodule

// File: hdl/qrs_bandpass_square_average.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_bandpass_square_average
// Sixth-order IIR bandpass, square of integer part, moving-window average.
// ----------------------------------------------------------------------------
//  channel  signals                          direction  notes
//  input    in_valid, in_stall, sample_in    in / out   one ECG sample per request
//  output   out_valid, out_stall, energy_avg out / in   registered, zero or one per item
//  config   cfg_wr_en, cfg_index, cfg_data   in         eight Q5.27 coefficients
//
//  An item passes through ten multiply steps on the one shared 32x32 multiplier,
//  rounding, squaring (same multiplier), the window update and, once warm-up is over,
//  a restoring divide over the 46-bit window sum, which takes most of an item's time.
//  in_stall is high from acceptance until the result sits in the output register,
//  or during warm-up until the window update is done. A result waiting under out_stall
//  does not block the next request; its finish does. Reset clears histories, window sum
//  and fill count; no clearing pass is needed.
module qrs_bandpass_square_average #(
	parameter int WINDOW      = 35,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [SAMPLE_BITS-1:0]         sample_in,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [qbsa_pkg::SQ_W-1:0]             energy_avg,
	input  logic                                  cfg_wr_en,
	input  logic [qbsa_pkg::REG_IDX_W-1:0]        cfg_index,
	input  logic [qbsa_pkg::COEF_W-1:0]           cfg_data
);

	localparam int PTR_W = $clog2(WINDOW);
	localparam int HALF  = WINDOW / 2;
	localparam int XPAD  = qbsa_pkg::COEF_W - SAMPLE_BITS;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_MAC    = 8'b0000_0010,
		ST_ROUND  = 8'b0000_0100,
		ST_SQUARE = 8'b0000_1000,
		ST_WIN    = 8'b0001_0000,
		ST_DSTART = 8'b0010_0000,
		ST_DWAIT  = 8'b0100_0000,
		ST_OUT    = 8'b1000_0000
	} state_t;

	function automatic logic signed [qbsa_pkg::COEF_W-1:0] sx(
		input logic [SAMPLE_BITS-1:0] v);
		return {{XPAD{v[SAMPLE_BITS-1]}}, v};
	endfunction

	state_t                                  state_q;
	qbsa_pkg::mac_step_t                     step_q;
	qbsa_pkg::mac_term_t                     term_q;
	qbsa_pkg::mac_term_t                     term_d;

	logic signed [qbsa_pkg::COEF_W-1:0]      coef_q [qbsa_pkg::NUM_REGS];
	logic signed [SAMPLE_BITS-1:0]           xh_q   [qbsa_pkg::HIST];
	logic signed [qbsa_pkg::Y_W-1:0]         yh_q   [qbsa_pkg::HIST];
	logic signed [SAMPLE_BITS-1:0]           x_q;
	logic signed [qbsa_pkg::Y_W-1:0]         y_q;
	logic signed [qbsa_pkg::ACC_W-1:0]       acc_q;
	logic signed [qbsa_pkg::PROD_W-1:0]      prod_q;
	logic signed [qbsa_pkg::COEF_W-1:0]      mul_a;
	logic signed [qbsa_pkg::COEF_W-1:0]      mul_b;
	logic signed [qbsa_pkg::ACC_W-1:0]       term_val;

	logic [qbsa_pkg::ACC_W-1:0]              acc_rnd;
	logic [qbsa_pkg::RND_W-1:0]              rnd_hi;
	logic [qbsa_pkg::RND_W-qbsa_pkg::Y_W:0]  rnd_top;
	logic signed [qbsa_pkg::Y_W-1:0]         y_sat;
	logic signed [qbsa_pkg::COEF_W-1:0]      ip_ext;

	logic [qbsa_pkg::SQ_W-1:0]               win_mem [WINDOW];
	logic [qbsa_pkg::SQ_W-1:0]               old_q;
	logic [qbsa_pkg::SQ_W-1:0]               old_val;
	logic [qbsa_pkg::SQ_W-1:0]               sq;
	logic [PTR_W-1:0]                        ptr_q;
	logic [qbsa_pkg::SUM_W-1:0]              sum_q;
	logic [qbsa_pkg::CNT_W-1:0]              cnt_q;
	logic [qbsa_pkg::CNT_W-1:0]              cnt_next;
	logic                                    win_full;

	qbsa_pkg::div_stat_t                     div_stat;
	logic [qbsa_pkg::SUM_W-1:0]              quotient;
	logic [qbsa_pkg::SQ_W-1:0]               avg_sat;
	logic                                    out_free;
	logic                                    in_take;

	logic                                    out_valid_q;
	logic [qbsa_pkg::SQ_W-1:0]               avg_q;

	assign in_stall = state_q != ST_IDLE;
	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// ---------------- shared multiplier operand selection ----------------
	assign ip_ext = {{qbsa_pkg::INT_SHIFT{y_q[qbsa_pkg::Y_W-1]}},
		y_q[qbsa_pkg::Y_W-1:qbsa_pkg::INT_SHIFT]};

	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		term_d = '0;
		if (state_q == ST_SQUARE) begin
			mul_a = ip_ext;
			mul_b = ip_ext;
		end else begin
			case (step_q)
				qbsa_pkg::MS_X0: begin
					mul_a  = coef_q[qbsa_pkg::REG_B_OUTER];
					mul_b  = sx(x_q);
					term_d = '{valid: 1'b1, sub: 1'b0, fb: 1'b0};
				end
				qbsa_pkg::MS_X2: begin
					mul_a  = coef_q[qbsa_pkg::REG_B_INNER];
					mul_b  = sx(xh_q[1]);
					term_d = '{valid: 1'b1, sub: 1'b0, fb: 1'b0};
				end
				qbsa_pkg::MS_X4: begin
					mul_a  = coef_q[qbsa_pkg::REG_B_INNER];
					mul_b  = sx(xh_q[3]);
					term_d = '{valid: 1'b1, sub: 1'b1, fb: 1'b0};
				end
				qbsa_pkg::MS_X6: begin
					mul_a  = coef_q[qbsa_pkg::REG_B_OUTER];
					mul_b  = sx(xh_q[5]);
					term_d = '{valid: 1'b1, sub: 1'b1, fb: 1'b0};
				end
				qbsa_pkg::MS_Y1: begin
					mul_a  = coef_q[qbsa_pkg::REG_A1];
					mul_b  = yh_q[0];
					term_d = '{valid: 1'b1, sub: 1'b1, fb: 1'b1};
				end
				qbsa_pkg::MS_Y2: begin
					mul_a  = coef_q[qbsa_pkg::REG_A2];
					mul_b  = yh_q[1];
					term_d = '{valid: 1'b1, sub: 1'b1, fb: 1'b1};
				end
				qbsa_pkg::MS_Y3: begin
					mul_a  = coef_q[qbsa_pkg::REG_A3];
					mul_b  = yh_q[2];
					term_d = '{valid: 1'b1, sub: 1'b1, fb: 1'b1};
				end
				qbsa_pkg::MS_Y4: begin
					mul_a  = coef_q[qbsa_pkg::REG_A4];
					mul_b  = yh_q[3];
					term_d = '{valid: 1'b1, sub: 1'b1, fb: 1'b1};
				end
				qbsa_pkg::MS_Y5: begin
					mul_a  = coef_q[qbsa_pkg::REG_A5];
					mul_b  = yh_q[4];
					term_d = '{valid: 1'b1, sub: 1'b1, fb: 1'b1};
				end
				qbsa_pkg::MS_Y6: begin
					mul_a  = coef_q[qbsa_pkg::REG_A6];
					mul_b  = yh_q[5];
					term_d = '{valid: 1'b1, sub: 1'b1, fb: 1'b1};
				end
				default: begin
					mul_a  = '0;
					mul_b  = '0;
					term_d = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// feedback products are Q.39: floor shift back to Q.27
	assign term_val = term_q.fb
		? {{(qbsa_pkg::ACC_W - qbsa_pkg::PROD_W + qbsa_pkg::FB_SHIFT){prod_q[qbsa_pkg::PROD_W-1]}},
			prod_q[qbsa_pkg::PROD_W-1:qbsa_pkg::FB_SHIFT]}
		: prod_q[qbsa_pkg::ACC_W-1:0];

	// round half up to Q.12, then clamp to 32 bits
	assign acc_rnd = acc_q + qbsa_pkg::ROUND_ADD;
	assign rnd_hi  = acc_rnd[qbsa_pkg::ACC_W-1:qbsa_pkg::OUT_SHIFT];
	assign rnd_top = rnd_hi[qbsa_pkg::RND_W-1:qbsa_pkg::Y_W-1];

	always_comb begin
		if (&rnd_top || ~|rnd_top) begin
			y_sat = rnd_hi[qbsa_pkg::Y_W-1:0];
		end else if (rnd_hi[qbsa_pkg::RND_W-1]) begin
			y_sat = {1'b1, {(qbsa_pkg::Y_W-1){1'b0}}};
		end else begin
			y_sat = {1'b0, {(qbsa_pkg::Y_W-1){1'b1}}};
		end
	end

	// ---------------- window ----------------
	assign sq       = (|prod_q[qbsa_pkg::PROD_W-1:qbsa_pkg::SQ_W]) ? '1
		: prod_q[qbsa_pkg::SQ_W-1:0];
	assign win_full = cnt_q == qbsa_pkg::CNT_W'(WINDOW);
	// slots not yet written since reset hold zero by definition
	assign old_val  = win_full ? old_q : '0;
	assign cnt_next = win_full ? cnt_q : cnt_q + 1'b1;

	always_ff @(posedge clk) begin
		if (state_q == ST_WIN) begin
			win_mem[ptr_q] <= sq;
		end
		old_q <= win_mem[ptr_q];
	end

	// ---------------- divider ----------------
	qbsa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_DSTART),
		.dividend (sum_q),
		.divisor  (cnt_q),
		.stat     (div_stat),
		.quotient (quotient)
	);

	assign avg_sat = (|quotient[qbsa_pkg::SUM_W-1:qbsa_pkg::SQ_W]) ? '1
		: quotient[qbsa_pkg::SQ_W-1:0];

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= qbsa_pkg::COEF_RESET;
		end else if (cfg_wr_en) begin
			coef_q[cfg_index] <= cfg_data;
		end
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= qbsa_pkg::MS_X0;
			term_q      <= '0;
			xh_q        <= '{default: '0};
			yh_q        <= '{default: '0};
			ptr_q       <= '0;
			sum_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// the output step reloads the register itself
			if (out_valid_q && !out_stall && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					term_q <= '0;
					step_q <= qbsa_pkg::MS_X0;
					if (in_take) begin
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					term_q <= term_d;
					step_q <= qbsa_pkg::mac_step_t'(step_q + 4'd1);
					if (step_q == qbsa_pkg::MS_DRAIN) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					for (int i = qbsa_pkg::HIST - 1; i > 0; i--) begin
						xh_q[i] <= xh_q[i-1];
						yh_q[i] <= yh_q[i-1];
					end
					xh_q[0] <= x_q;
					yh_q[0] <= y_sat;
					state_q <= ST_SQUARE;
				end
				ST_SQUARE: begin
					state_q <= ST_WIN;
				end
				ST_WIN: begin
					sum_q <= sum_q - qbsa_pkg::SUM_W'(old_val) + qbsa_pkg::SUM_W'(sq);
					cnt_q <= cnt_next;
					ptr_q <= (ptr_q == PTR_W'(WINDOW - 1)) ? '0 : ptr_q + 1'b1;
					// warm-up: first WINDOW/2 items give no result
					state_q <= (cnt_next > qbsa_pkg::CNT_W'(HALF)) ? ST_DSTART : ST_IDLE;
				end
				ST_DSTART: begin
					state_q <= ST_DWAIT;
				end
				ST_DWAIT: begin
					if (div_stat.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			x_q   <= sample_in;
			acc_q <= '0;
		end else if (state_q == ST_MAC && term_q.valid) begin
			acc_q <= term_q.sub ? acc_q - term_val : acc_q + term_val;
		end
		if (state_q == ST_ROUND) begin
			y_q <= y_sat;
		end
		if (state_q == ST_OUT && out_free) begin
			avg_q <= avg_sat;
		end
	end

	assign out_valid  = out_valid_q;
	assign energy_avg = avg_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= qbsa_pkg::CNT_W'(WINDOW))
		else $error("fill count beyond window");

	a_fill_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < qbsa_pkg::CNT_W'(WINDOW) |-> qbsa_pkg::CNT_W'(ptr_q) == cnt_q)
		else $error("window pointer out of step with fill count");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result presented outside the output step");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !div_stat.busy)
		else $error("divider busy while sequencer idle");

endmodule
